FILE: src/rsv_pkg.sv
// Shared widths and constants for the signature verify pipeline.
`default_nettype none
package rsv_pkg;
  localparam int W = 24;
  localparam int MSG_W = 40;
  localparam logic [31:0] HASH_SEED = 32'h00AB_CDEF;
  localparam int HASH_STEP = 13;
  localparam int ROT = 5;
  typedef logic [W-1:0] word_t;
endpackage
`default_nettype wire

FILE: src/rsv_cell.sv
// One step of an interleaved modular multiplication: r = 2r + abit*b mod n.
`default_nettype none
module rsv_cell
  import rsv_pkg::*;
#(
  parameter int SIDE_W = 24
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              v_i,
  input  wire word_t             r_i,
  input  wire word_t             a_i,
  input  wire word_t             b_i,
  input  wire word_t             n_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   v_o,
  output word_t                  r_o,
  output word_t                  a_o,
  output word_t                  b_o,
  output word_t                  n_o,
  output logic [SIDE_W-1:0]      side_o
);
  logic [W+1:0] t;
  logic [W+1:0] n1;
  logic [W+1:0] n2;
  word_t        r_next;

  // Since r and b are below n, t stays below 3n and two subtractions suffice.
  always_comb begin
    n1 = {2'b00, n_i};
    n2 = {1'b0, n_i, 1'b0};
    t = {1'b0, r_i, 1'b0} + (a_i[W-1] ? {2'b00, b_i} : '0);
    if (t >= n2) begin
      r_next = W'(t - n2);
    end else if (t >= n1) begin
      r_next = W'(t - n1);
    end else begin
      r_next = W'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_o    <= r_next;
      a_o    <= {a_i[W-2:0], 1'b0};
      b_o    <= b_i;
      n_o    <= n_i;
      side_o <= side_i;
    end
  end
endmodule
`default_nettype wire

FILE: src/rsv_modmul.sv
// A chain of cells that computes a*b mod n, one multiplier bit per cell.
`default_nettype none
module rsv_modmul
  import rsv_pkg::*;
#(
  parameter int SIDE_W = 24
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              v_i,
  input  wire word_t             a_i,
  input  wire word_t             b_i,
  input  wire word_t             n_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   v_o,
  output word_t                  p_o,
  output word_t                  n_o,
  output logic [SIDE_W-1:0]      side_o
);
  logic              v [0:W];
  word_t             r [0:W];
  word_t             a [0:W];
  word_t             b [0:W];
  word_t             n [0:W];
  logic [SIDE_W-1:0] sd [0:W];

  assign v[0]  = v_i;
  assign r[0]  = '0;
  assign a[0]  = a_i;
  assign b[0]  = b_i;
  assign n[0]  = n_i;
  assign sd[0] = side_i;

  for (genvar k = 0; k < W; k++) begin : g_cell
    rsv_cell #(.SIDE_W(SIDE_W)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .v_i(v[k]), .r_i(r[k]), .a_i(a[k]), .b_i(b[k]), .n_i(n[k]), .side_i(sd[k]),
      .v_o(v[k+1]), .r_o(r[k+1]), .a_o(a[k+1]), .b_o(b[k+1]), .n_o(n[k+1]),
      .side_o(sd[k+1])
    );
  end

  assign v_o    = v[W] & (a[W] == '0) & (b[W] == b[W]);
  assign p_o    = r[W];
  assign n_o    = n[W];
  assign side_o = sd[W];
endmodule
`default_nettype wire

FILE: src/rsa_signature_verify_24bit.sv
// Top level of the small-modulus RSA signature check with exponent 17.
// Pipeline: one input register, seven chains of 24 cells, one output register.
// Throughput: one request per cycle unless out_stall holds a finished
// result; each cell retires one multiplier bit.
// Reset: rst is synchronous; it clears all valid bits and sets the modulus to 1.
`default_nettype none
module rsa_signature_verify_24bit
  import rsv_pkg::*;
#(
  parameter int MESSAGE_BYTES = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             public_modulus_we,
  input  wire logic [W-1:0]     public_modulus_wdata,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [MSG_W-1:0] message_bytes,
  input  wire logic [W-1:0]     signature,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [W-1:0]          hash_mod,
  output logic [W-1:0]          recovered,
  output logic                  match
);
  // The whole pipeline advances together unless a finished result is held.
  logic  en;
  word_t modulus;
  logic [31:0] h;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // A write of zero is stored as one.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= W'(1);
    end else if (public_modulus_we) begin
      modulus <= (public_modulus_wdata == '0) ? W'(1) : public_modulus_wdata;
    end
  end

  // The hash is short enough to compute in the input stage. Byte i is taken
  // from the top of the message field; bytes above the field read as zero.
  always_comb begin
    h = HASH_SEED;
    for (int i = 0; i < MESSAGE_BYTES; i++) begin
      h = h ^ (32'(8'(message_bytes >> (8 * (MESSAGE_BYTES - 1 - i))))
               + 32'(i * HASH_STEP));
      h = {h[31-ROT:0], h[31:32-ROT]};
    end
  end

  logic  v0;
  word_t h0, s0, n0, one0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  // Reductions use the multiplier with b = 1 mod n, which is zero when n is one.
  always_ff @(posedge clk) begin
    if (en) begin
      h0   <= h[W-1:0];
      s0   <= signature;
      n0   <= modulus;
      one0 <= (modulus == W'(1)) ? '0 : W'(1);
    end
  end

  // Reduce the hash; the signature rides along.
  logic  v1;
  word_t hm1, n1, s1;
  rsv_modmul #(.SIDE_W(W)) u_red_hash (
    .clk(clk), .rst(rst), .en(en),
    .v_i(v0), .a_i(h0), .b_i(one0), .n_i(n0), .side_i(s0),
    .v_o(v1), .p_o(hm1), .n_o(n1), .side_o(s1)
  );

  // Reduce the signature; the reduced hash rides along.
  logic  v2;
  word_t x1, n2, hm2;
  rsv_modmul #(.SIDE_W(W)) u_red_sig (
    .clk(clk), .rst(rst), .en(en),
    .v_i(v1), .a_i(s1), .b_i((n1 == W'(1)) ? '0 : W'(1)), .n_i(n1), .side_i(hm1),
    .v_o(v2), .p_o(x1), .n_o(n2), .side_o(hm2)
  );

  // Four squarings give x^16; the side word carries the hash and x.
  logic              vq [0:4];
  word_t             xq [0:4];
  word_t             nq [0:4];
  logic [2*W-1:0]    sq [0:4];

  assign vq[0] = v2;
  assign xq[0] = x1;
  assign nq[0] = n2;
  assign sq[0] = {hm2, x1};

  for (genvar k = 0; k < 4; k++) begin : g_sq
    rsv_modmul #(.SIDE_W(2*W)) u_sq (
      .clk(clk), .rst(rst), .en(en),
      .v_i(vq[k]), .a_i(xq[k]), .b_i(xq[k]), .n_i(nq[k]), .side_i(sq[k]),
      .v_o(vq[k+1]), .p_o(xq[k+1]), .n_o(nq[k+1]), .side_o(sq[k+1])
    );
  end

  // Final multiply by x gives x^17.
  logic  v3;
  word_t rec3, n3, hm3;
  rsv_modmul #(.SIDE_W(W)) u_mul (
    .clk(clk), .rst(rst), .en(en),
    .v_i(vq[4]), .a_i(xq[4]), .b_i(sq[4][W-1:0]), .n_i(nq[4]), .side_i(sq[4][2*W-1:W]),
    .v_o(v3), .p_o(rec3), .n_o(n3), .side_o(hm3)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3 && (n3 != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hash_mod  <= hm3;
      recovered <= rec3;
      match     <= (rec3 == hm3);
    end
  end
endmodule
`default_nettype wire
